### design/sdf_pkg.sv
package sdf_pkg;

  localparam int IN_TDATA_W  = 48;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int SHIFT_W     = 40;
  localparam int NBYTES_W    = 3;

  localparam logic [1:0] CMD_FRAME = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_DATA  = 2'd2;
  localparam logic [1:0] CMD_END   = 2'd3;

  localparam logic [CFG_ADDR_W-1:0] ADDR_CRC_ENABLE = 3'd0;

  localparam logic [6:0]  CRC7_POLY    = 7'h09;
  localparam logic [15:0] CRC16_POLY   = 16'h1021;
  localparam logic [7:0]  CMD_PREFIX   = 8'h40;
  localparam logic        CRC7_END     = 1'b1;
  localparam logic [7:0]  STUFF_BYTE   = 8'hFF;
  localparam logic [7:0]  TOKEN_SINGLE = 8'hFE;
  localparam logic [7:0]  TOKEN_MULTI  = 8'hFC;

  localparam logic [NBYTES_W-1:0] LEN_FRAME = 3'd6;
  localparam logic [NBYTES_W-1:0] LEN_ONE   = 3'd1;
  localparam logic [NBYTES_W-1:0] LEN_END   = 3'd2;

  // One queued request: bytes left-aligned, sent from the top byte down
  typedef struct packed {
    logic                is_frame;
    logic                crc_en;
    logic [NBYTES_W-1:0] nbytes;
    logic [SHIFT_W-1:0]  data;
  } q_entry_t;

  function automatic logic [6:0] crc7_byte(input logic [6:0] crc_in, input logic [7:0] b);
    logic [6:0] c;
    logic       fb;
    c = crc_in;
    for (int i = 7; i >= 0; i--) begin
      fb = c[6] ^ b[i];
      c  = {c[5:0], 1'b0};
      if (fb) begin
        c = c ^ CRC7_POLY;
      end
    end
    return c;
  endfunction

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC16_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### design/sd_spi_command_data_framer.sv
// SD-card SPI transmit framer.
// Input stream: in_tuser selects the request (frame command, block start,
// data byte, block end); in_tdata carries its fields. Output stream: one
// MOSI byte per transfer, out_tlast on the final byte of each request.
// A frame command gives six bytes (0x40|index, argument MSB first, CRC7
// with end bit); block start gives the 0xFE/0xFC token and clears the
// CRC16; a data byte is echoed and folded into the CRC16; block end gives
// the CRC16 high then low. With crc_enable clear, CRC bytes read 0xFF.
// The front end takes one request per cycle while the queue has room and
// updates the CRC16 on acceptance; the serializer sends one byte per cycle
// while the receiver is ready, as do data byte requests. A byte passes the
// queue, current and output registers. A frame command holds the serializer
// for six bytes, block end for two. On a receiver stall the output register
// holds and the queue (QUEUE_DEPTH requests) fills before in_tready drops.
// Reset empties the queue, clears the CRC16 and sets crc_enable.
module sd_spi_command_data_framer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [5:0] cmd_index, [37:6] argument, [38] multi_block, [46:39] data_byte
  input  logic [sdf_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [1:0] command
  input  logic [sdf_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [7:0] out_byte
  output logic [sdf_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sdf_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [sdf_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [sdf_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import sdf_pkg::*;

  logic     crc_enable_r;
  logic     cfg_wr;
  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_valid;
  q_entry_t q_wdata;
  q_entry_t q_rdata;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // register index is paddr[2]; byte lanes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_enable_r <= 1'b1;
    end else if (cfg_wr && (paddr[2] == ADDR_CRC_ENABLE[2])) begin
      crc_enable_r <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == ADDR_CRC_ENABLE[2]) ? {31'h0, crc_enable_r} : '0;

  sdf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .crc_enable (crc_enable_r),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  sdf_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  sdf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

### design/sdf_front.sv
module sdf_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           crc_enable,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [sdf_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic [sdf_pkg::IN_TUSER_W-1:0] in_tuser,
  input  logic                           q_full,
  output logic                           q_push,
  output sdf_pkg::q_entry_t              q_wdata
);
  import sdf_pkg::*;

  logic [5:0]  cmd_index;
  logic [31:0] argument;
  logic        multi_block;
  logic [7:0]  data_byte;
  logic [15:0] data_crc_r;
  logic [15:0] data_crc_nxt;

  assign cmd_index   = in_tdata[5:0];
  assign argument    = in_tdata[37:6];
  assign multi_block = in_tdata[38];
  assign data_byte   = in_tdata[46:39];

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    data_crc_nxt     = data_crc_r;
    q_wdata.is_frame = 1'b0;
    q_wdata.crc_en   = crc_enable;
    q_wdata.nbytes   = LEN_ONE;
    q_wdata.data     = '0;
    unique case (in_tuser)
      CMD_FRAME: begin
        q_wdata.is_frame = 1'b1;
        q_wdata.nbytes   = LEN_FRAME;
        q_wdata.data     = {CMD_PREFIX | {2'b00, cmd_index}, argument};
      end
      CMD_START: begin
        data_crc_nxt = '0;
        q_wdata.data = {(multi_block ? TOKEN_MULTI : TOKEN_SINGLE), 32'h0};
      end
      CMD_DATA: begin
        data_crc_nxt = crc16_byte(data_crc_r, data_byte);
        q_wdata.data = {data_byte, 32'h0};
      end
      CMD_END: begin
        q_wdata.nbytes = LEN_END;
        q_wdata.data   = {(crc_enable ? data_crc_r : {STUFF_BYTE, STUFF_BYTE}), 24'h0};
      end
      default: begin
        q_wdata.data = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_crc_r <= '0;
    end else if (q_push) begin
      data_crc_r <= data_crc_nxt;
    end
  end

endmodule

### design/sdf_fifo.sv
module sdf_fifo #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sdf_pkg::q_entry_t wdata,
  output logic              full,
  input  logic              pop,
  output logic              rvalid,
  output sdf_pkg::q_entry_t rdata
);
  import sdf_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  q_entry_t          slot_r [DEPTH];
  logic [PtrW-1:0]   wr_ptr_r;
  logic [PtrW-1:0]   rd_ptr_r;
  logic [CntW-1:0]   count_r;
  logic              do_push;
  logic              do_pop;

  assign full    = (count_r == CntW'(DEPTH));
  assign rvalid  = (count_r != '0);
  assign rdata   = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && rvalid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

### design/sdf_back.sv
module sdf_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  input  sdf_pkg::q_entry_t               q_rdata,
  output logic                            q_pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [sdf_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast
);
  import sdf_pkg::*;

  logic                cur_valid_r;
  logic [SHIFT_W-1:0]  shift_r;
  logic [NBYTES_W-1:0] rem_r;
  logic                is_frame_r;
  logic                crc_en_r;
  logic [6:0]          crc7_r;
  logic                out_valid_r;
  logic [7:0]          out_byte_r;
  logic                out_last_r;

  logic       emit;
  logic       final_byte;
  logic       load;
  logic [7:0] cur_byte;

  assign emit       = cur_valid_r && (!out_valid_r || out_tready);
  assign final_byte = (rem_r == LEN_ONE);
  assign load       = q_valid && (!cur_valid_r || (emit && final_byte));
  assign q_pop      = load;

  always_comb begin
    if (is_frame_r && final_byte) begin
      cur_byte = crc_en_r ? {crc7_r, CRC7_END} : STUFF_BYTE;
    end else begin
      cur_byte = shift_r[SHIFT_W-1 -: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
    end else if (load) begin
      cur_valid_r <= 1'b1;
    end else if (emit && final_byte) begin
      cur_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      shift_r    <= q_rdata.data;
      rem_r      <= q_rdata.nbytes;
      is_frame_r <= q_rdata.is_frame;
      crc_en_r   <= q_rdata.crc_en;
      crc7_r     <= '0;
    end else if (emit) begin
      shift_r <= {shift_r[SHIFT_W-9:0], 8'h00};
      rem_r   <= rem_r - 1'b1;
      crc7_r  <= crc7_byte(crc7_r, shift_r[SHIFT_W-1 -: 8]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= cur_byte;
      out_last_r <= final_byte;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;

endmodule

### design/sdf_checker.sv
module sdf_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [sdf_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic [sdf_pkg::IN_TUSER_W-1:0]  in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [sdf_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tlast,
  input logic                            psel,
  input logic                            penable,
  input logic                            pwrite,
  input logic [sdf_pkg::CFG_ADDR_W-1:0]  paddr,
  input logic [sdf_pkg::CFG_DATA_W-1:0]  pwdata,
  input logic [sdf_pkg::CFG_DATA_W-1:0]  prdata,
  input logic                            pready
);
  import sdf_pkg::*;

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata) && $stable(in_tuser))
    else $error("waiting request changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output changed");

  a_reset_no_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid straight after reset");

  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready straight after reset");

  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && pready && (paddr[2] == ADDR_CRC_ENABLE[2])
      |=> (paddr[2] != ADDR_CRC_ENABLE[2]) || (prdata[0] == $past(pwdata[0])))
    else $error("crc_enable readback mismatch");

endmodule

bind sd_spi_command_data_framer sdf_checker u_sdf_checker (.*);

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import sdf_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int LONG_HOLD = 80;
  localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED = 3'd4;

  typedef enum {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [5:0]  idx;
    logic [31:0] arg;
    logic        multi;
    logic [7:0]  dbyte;
  } req_t;

  typedef struct packed {
    logic [7:0] mosi;
    logic       last;
  } mosi_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [IN_TUSER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tlast;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  req_t  pending_reqs[$];
  mosi_t mosi_due[$];
  logic [15:0] blk_crc;
  logic crc_on;
  logic in_fire = 1'b0;
  int errors = 0;
  int cycle_cnt = 0;
  int tx_gap = 0;
  int tx_burst = 0;
  int tx_gap_max = 4;
  rx_mode_t rx_mode = RX_RANDOM;
  int rx_hold = 0;
  int rx_phase = 0;
  int hold_token = 0;
  int hold_seen = 0;

  sd_spi_command_data_framer i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [6:0] crc7_fold(input logic [6:0] c, input logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[6] ^ b[i];
      c = {c[5:0], 1'b0} ^ (fb ? CRC7_POLY : 7'h00);
    end
    return c;
  endfunction

  function automatic logic [15:0] crc16_fold(input logic [15:0] c, input logic [7:0] b);
    logic msb;
    c[15:8] = c[15:8] ^ b;
    for (int i = 0; i < 8; i++) begin
      msb = c[15];
      c = {c[14:0], 1'b0} ^ (msb ? CRC16_POLY : 16'h0000);
    end
    return c;
  endfunction

  function automatic void queue_mosi_bytes(input req_t r);
    logic [7:0] hdr[5];
    logic [6:0] c7;
    hdr[0] = CMD_PREFIX | {2'b00, r.idx};
    hdr[1] = r.arg[31:24];
    hdr[2] = r.arg[23:16];
    hdr[3] = r.arg[15:8];
    hdr[4] = r.arg[7:0];
    c7 = '0;
    case (r.command)
      CMD_FRAME: begin
        for (int k = 0; k < 5; k++) begin
          c7 = crc7_fold(c7, hdr[k]);
          mosi_due.push_back('{hdr[k], 1'b0});
        end
        mosi_due.push_back('{crc_on ? {c7, CRC7_END} : STUFF_BYTE, 1'b1});
      end
      CMD_START: begin
        blk_crc = '0;
        mosi_due.push_back('{r.multi ? TOKEN_MULTI : TOKEN_SINGLE, 1'b1});
      end
      CMD_DATA: begin
        blk_crc = crc16_fold(blk_crc, r.dbyte);
        mosi_due.push_back('{r.dbyte, 1'b1});
      end
      default: begin
        mosi_due.push_back('{crc_on ? blk_crc[15:8] : STUFF_BYTE, 1'b0});
        mosi_due.push_back('{crc_on ? blk_crc[7:0] : STUFF_BYTE, 1'b1});
      end
    endcase
  endfunction

  // Monitor: sample at the rising edge
  always @(posedge clk) begin
    mosi_t due;
    req_t  seen;
    cycle_cnt++;
    in_fire <= in_tvalid && in_tready;
    if (!rst_n) begin
      blk_crc = '0;
      crc_on = 1'b1;
    end else begin
      if (out_tvalid && out_tready) begin
        if (mosi_due.size() == 0) begin
          $error("out_tdata: no byte expected, got %h", out_tdata);
          errors++;
        end else begin
          due = mosi_due.pop_front();
          if (out_tdata !== due.mosi) begin
            $error("out_byte: expected %h, got %h", due.mosi, out_tdata);
            errors++;
          end
          if (out_tlast !== due.last) begin
            $error("last: expected %b, got %b", due.last, out_tlast);
            errors++;
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr == ADDR_CRC_ENABLE) begin
        crc_on = pwdata[0];
      end
      if (in_tvalid && in_tready) begin
        seen.command = in_tuser;
        seen.idx = in_tdata[5:0];
        seen.arg = in_tdata[37:6];
        seen.multi = in_tdata[38];
        seen.dbyte = in_tdata[46:39];
        queue_mosi_bytes(seen);
      end
    end
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Request driver: bursts with random gaps
  always @(negedge clk) begin
    req_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_fire) begin
    end else if (tx_gap > 0 || pending_reqs.size() == 0) begin
      in_tvalid <= 1'b0;
      if (tx_gap > 0) tx_gap--;
    end else begin
      nxt = pending_reqs.pop_front();
      in_tuser <= nxt.command;
      in_tdata <= {1'b0, nxt.dbyte, nxt.multi, nxt.arg, nxt.idx};
      in_tvalid <= 1'b1;
      if (tx_burst == 0) begin
        tx_burst = $urandom_range(1, 12);
        tx_gap = $urandom_range(0, tx_gap_max);
      end else begin
        tx_burst--;
      end
    end
  end

  // Receiver stalls
  always @(negedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      rx_hold = LONG_HOLD;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN: out_tready <= 1'b1;
        RX_RANDOM: out_tready <= ($urandom_range(0, 2) != 0);
        default: begin
          rx_phase = (rx_phase + 1) % 7;
          out_tready <= (rx_phase < 3);
        end
      endcase
    end
  end

  function automatic req_t rand_req(input logic [1:0] cmd);
    req_t r;
    r.command = cmd;
    r.idx = 6'($urandom_range(0, 63));
    r.arg = $urandom;
    r.multi = 1'($urandom_range(0, 1));
    r.dbyte = 8'($urandom_range(0, 255));
    return r;
  endfunction

  task automatic push_req(input logic [1:0] cmd, input logic [5:0] idx, input logic [31:0] arg,
                          input logic multi, input logic [7:0] dbyte);
    pending_reqs.push_back('{cmd, idx, arg, multi, dbyte});
  endtask

  task automatic add_random(input int count);
    int added;
    int ndata;
    added = 0;
    while (added < count) begin
      if ($urandom_range(0, 9) < 8) begin
        pending_reqs.push_back(rand_req(CMD_FRAME));
        pending_reqs.push_back(rand_req(CMD_START));
        ndata = ($urandom_range(0, 9) == 0) ? 20 : $urandom_range(0, 5);
        repeat (ndata) pending_reqs.push_back(rand_req(CMD_DATA));
        pending_reqs.push_back(rand_req(CMD_END));
        added += ndata + 3;
        if ($urandom_range(0, 7) == 0) begin
          pending_reqs.push_back(rand_req(CMD_END));
          added++;
        end
      end else begin
        pending_reqs.push_back(rand_req(2'($urandom_range(0, 3))));
        added++;
      end
    end
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_tvalid || mosi_due.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic cfg_check();
    logic [31:0] rd;
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b0;
    paddr = ADDR_CRC_ENABLE;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    if (rd !== {31'b0, crc_on}) begin
      $error("crc_enable: expected %h, got %h", {31'b0, crc_on}, rd);
      errors++;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    cfg_check();

    // CRC on after reset
    push_req(CMD_FRAME, 6'd0, 32'h0000_0000, 1'b0, 8'h00);
    push_req(CMD_FRAME, 6'd63, 32'hFFFF_FFFF, 1'b1, 8'hFF);
    push_req(CMD_START, 6'd63, 32'hFFFF_FFFF, 1'b0, 8'hFF);
    push_req(CMD_DATA, 6'd0, 32'h0, 1'b1, 8'h00);
    push_req(CMD_DATA, 6'd0, 32'h0, 1'b0, 8'hFF);
    push_req(CMD_DATA, 6'd21, 32'hDEAD_BEEF, 1'b1, 8'h5A);
    push_req(CMD_END, 6'd0, 32'h0, 1'b0, 8'h00);
    push_req(CMD_END, 6'd63, 32'hFFFF_FFFF, 1'b1, 8'hFF);
    push_req(CMD_DATA, 6'd0, 32'h0, 1'b0, 8'h3C);
    push_req(CMD_FRAME, 6'd17, 32'h1234_5678, 1'b1, 8'h81);
    push_req(CMD_END, 6'd0, 32'h0, 1'b0, 8'h00);
    push_req(CMD_START, 6'd0, 32'h0, 1'b1, 8'h00);
    push_req(CMD_DATA, 6'd0, 32'h0, 1'b0, 8'hA5);
    push_req(CMD_END, 6'd0, 32'h0, 1'b0, 8'h00);
    wait_idle();

    // CRC off, then switched back on in the middle of a block
    cfg_write(ADDR_CRC_ENABLE, 32'h0000_0000);
    cfg_write(ADDR_UNMAPPED, 32'hFFFF_FFFF);
    cfg_check();
    push_req(CMD_FRAME, 6'd8, 32'h0000_01AA, 1'b0, 8'h00);
    push_req(CMD_START, 6'd0, 32'h0, 1'b0, 8'h00);
    push_req(CMD_DATA, 6'd0, 32'h0, 1'b0, 8'h11);
    push_req(CMD_END, 6'd0, 32'h0, 1'b0, 8'h00);
    push_req(CMD_START, 6'd0, 32'h0, 1'b1, 8'h00);
    push_req(CMD_DATA, 6'd0, 32'h0, 1'b0, 8'h80);
    push_req(CMD_DATA, 6'd0, 32'h0, 1'b0, 8'h01);
    wait_idle();
    cfg_write(ADDR_CRC_ENABLE, 32'hFFFF_FFFF);
    cfg_check();
    push_req(CMD_DATA, 6'd0, 32'h0, 1'b0, 8'h7E);
    push_req(CMD_END, 6'd0, 32'h0, 1'b0, 8'h00);
    push_req(CMD_FRAME, 6'd55, 32'h8000_0001, 1'b0, 8'h00);
    wait_idle();

    // random, long receiver hold while requests keep coming
    rx_mode = RX_RANDOM;
    tx_gap_max = 6;
    add_random(40);
    @(posedge clk);
    hold_token++;
    wait_idle();

    cfg_write(ADDR_CRC_ENABLE, 32'h0000_0000);
    cfg_check();
    rx_mode = RX_PATTERN;
    tx_gap_max = 3;
    add_random(30);
    wait_idle();

    cfg_write(ADDR_CRC_ENABLE, 32'h0000_0001);
    cfg_check();
    rx_mode = RX_OPEN;
    tx_gap_max = 0;
    add_random(50);
    wait_idle();

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sd_spi_command_data_framer.f
design/sdf_pkg.sv
design/sdf_front.sv
design/sdf_fifo.sv
design/sdf_back.sv
design/sd_spi_command_data_framer.sv
design/sdf_checker.sv
test/testbench.sv
